@@ rtl/rgba_box_downscale_2x2_macros.svh @@
// Assertion macros for the RGBA 2x2 box downscaler.
// Included by the top level; defining ASSERT_OFF removes every check.
`ifndef RGBA_BOX_DOWNSCALE_2X2_MACROS_SVH
`define RGBA_BOX_DOWNSCALE_2X2_MACROS_SVH
`ifndef ASSERT_OFF
`define RBD_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rbd check failed: same-cycle implication");
`define RBD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rbd check failed: next-cycle implication");
`else
`define RBD_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define RBD_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

@@ rtl/rbd_pkg.sv @@
// Types, constants and lane arithmetic for the RGBA 2x2 box downscaler.
// No dependencies.
`default_nettype none

package rbd_pkg;

    localparam int CHAN_W      = 8;
    localparam int LANE_W      = 10;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int HEIGHT_W    = 13;
    localparam int ROW_W       = 12;

    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
        logic              row_end;
        logic              frame_end;
    } pixel_out_t;

    typedef struct packed {
        logic [LANE_W-1:0] red;
        logic [LANE_W-1:0] green;
        logic [LANE_W-1:0] blue;
        logic [LANE_W-1:0] alpha;
    } lane_sum_t;

    localparam int LANE_SUM_W = $bits(lane_sum_t);

    function automatic logic [LANE_W-1:0] add_chan(logic [CHAN_W-1:0] a,
                                                   logic [CHAN_W-1:0] b);
        return LANE_W'(a) + LANE_W'(b);
    endfunction

    function automatic lane_sum_t pair_of(pixel_in_t a, pixel_in_t b);
        lane_sum_t s;
        s.red   = add_chan(a.red_in,   b.red_in);
        s.green = add_chan(a.green_in, b.green_in);
        s.blue  = add_chan(a.blue_in,  b.blue_in);
        s.alpha = add_chan(a.alpha_in, b.alpha_in);
        return s;
    endfunction

    // Rounded mean of four pixels given as two pair sums, kept to eight bits.
    function automatic logic [CHAN_W-1:0] round_mean(logic [LANE_W-1:0] a,
                                                     logic [LANE_W-1:0] b);
        logic [LANE_W:0] s;
        s = {1'b0, a} + {1'b0, b} + (LANE_W+1)'(2);
        return s[CHAN_W+1:2];
    endfunction

endpackage

`default_nettype wire

@@ rtl/rbd_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module rbd_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2048
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/rgba_box_downscale_2x2.sv @@
// RGBA8 2x2 box-filter downscaler, top level.
// Depends on rbd_pkg, rbd_ram and rgba_box_downscale_2x2_macros.svh.
//
// The block takes one source pixel per clock in raster order while s_ready
// is high and returns one registered pixel of the half-size image for each
// completed 2x2 block. Horizontal pair sums of even source rows go into a
// line RAM of MAX_WIDTH/2 entries with one write and one read port, which the
// odd row reads back; each item makes at most one access, so the sustained
// rate is one pixel per clock unless stalled. The line RAM needs no clearing
// pass after reset. Writing either size register restarts the frame.
`default_nettype none
`include "rgba_box_downscale_2x2_macros.svh"

module rgba_box_downscale_2x2 #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [rbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire rbd_pkg::pixel_in_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output rbd_pkg::pixel_out_t                   m_data
);

    import rbd_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WEFF_W     = $clog2(MAX_WIDTH + 1);

    logic [WEFF_W-1:0]   width_eff_reg,  width_eff_next;
    logic [HEIGHT_W-1:0] height_eff_reg, height_eff_next;
    logic [COL_W-1:0]    col_reg,        col_next;
    logic [ROW_W-1:0]    row_reg,        row_next;
    logic                s1_valid_reg,   s1_valid_next;
    logic                m_valid_reg,    m_valid_next;

    pixel_in_t           left_pixel_reg;
    lane_sum_t           s1_pair_reg;
    logic                s1_self_reg;
    logic                s1_row_end_reg;
    logic                s1_frame_end_reg;
    pixel_out_t          m_data_reg;

    logic                s_accept;
    logic                out_free;
    logic                w_one;
    logic                h_one;
    logic [WEFF_W-1:0]   out_w_last;
    logic [HEIGHT_W-1:0] out_h_last;
    logic                col_last;
    logic                row_last;
    logic                have_pair;
    logic                emit;
    logic                row_end_now;
    logic                frame_end_now;
    logic [LINE_AW-1:0]  line_addr;
    lane_sum_t           pair_now;
    logic                line_we;
    logic                line_re;
    logic [LANE_SUM_W-1:0] line_rd_data;
    lane_sum_t           other_pair;
    pixel_out_t          result;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;

    assign w_one      = (width_eff_reg == WEFF_W'(1));
    assign h_one      = (height_eff_reg == HEIGHT_W'(1));
    assign out_w_last = w_one ? '0 : (width_eff_reg >> 1) - WEFF_W'(1);
    assign out_h_last = h_one ? '0 : (height_eff_reg >> 1) - HEIGHT_W'(1);
    assign col_last   = (WEFF_W'(col_reg) == width_eff_reg - WEFF_W'(1));
    assign row_last   = (HEIGHT_W'(row_reg) == height_eff_reg - HEIGHT_W'(1));

    assign have_pair = w_one || col_reg[0];
    assign emit      = have_pair && (h_one || row_reg[0]);
    assign line_addr = w_one ? '0 : LINE_AW'(col_reg >> 1);
    assign pair_now  = w_one ? pair_of(s_data, s_data) : pair_of(left_pixel_reg, s_data);
    assign line_we   = s_accept && have_pair && !h_one && !row_reg[0];
    assign line_re   = s_accept && have_pair && !h_one && row_reg[0];

    assign row_end_now   = (WEFF_W'(line_addr) == out_w_last);
    assign frame_end_now = row_end_now && (HEIGHT_W'(row_reg >> 1) == out_h_last);

    always_comb begin
        width_eff_next  = width_eff_reg;
        height_eff_next = height_eff_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH: begin
                    if (cfg_data == '0) begin
                        width_eff_next = WEFF_W'(1);
                    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
                        width_eff_next = WEFF_W'(MAX_WIDTH);
                    end else begin
                        width_eff_next = WEFF_W'(cfg_data);
                    end
                    col_next = '0;
                    row_next = '0;
                end
                REG_SOURCE_HEIGHT: begin
                    if (cfg_data == '0) begin
                        height_eff_next = HEIGHT_W'(1);
                    end else if (cfg_data > HEIGHT_LIMIT) begin
                        height_eff_next = HEIGHT_LIMIT;
                    end else begin
                        height_eff_next = cfg_data;
                    end
                    col_next = '0;
                    row_next = '0;
                end
                default: begin
                end
            endcase
        end else if (s_accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        m_valid_next  = m_valid_reg;
        if (s_ready) begin
            s1_valid_next = s_accept && emit;
        end
        if (out_free) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_eff_reg  <= WEFF_W'(1);
            height_eff_reg <= HEIGHT_W'(1);
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            left_pixel_reg <= '0;
        end else begin
            width_eff_reg  <= width_eff_next;
            height_eff_reg <= height_eff_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            s1_valid_reg   <= s1_valid_next;
            m_valid_reg    <= m_valid_next;
            if (s_accept && !w_one && !col_reg[0]) begin
                left_pixel_reg <= s_data;
            end
        end
    end

    rbd_ram #(
        .WIDTH (LANE_SUM_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (line_we),
        .wr_addr (line_addr),
        .wr_data (pair_now),
        .rd_en   (line_re),
        .rd_addr (line_addr),
        .rd_data (line_rd_data)
    );

    assign other_pair = s1_self_reg ? s1_pair_reg : lane_sum_t'(line_rd_data);

    always_comb begin
        result.red_out   = round_mean(s1_pair_reg.red,   other_pair.red);
        result.green_out = round_mean(s1_pair_reg.green, other_pair.green);
        result.blue_out  = round_mean(s1_pair_reg.blue,  other_pair.blue);
        result.alpha_out = round_mean(s1_pair_reg.alpha, other_pair.alpha);
        result.row_end   = s1_row_end_reg;
        result.frame_end = s1_frame_end_reg;
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pair_reg      <= pair_now;
            s1_self_reg      <= h_one;
            s1_row_end_reg   <= row_end_now;
            s1_frame_end_reg <= frame_end_now;
        end
        if (out_free && s1_valid_reg) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RBD_ASSERT_IMPLY(a_line_port_exclusive, aclk, aresetn, line_we, !line_re)
    `RBD_ASSERT_IMPLY(a_stall_only_when_full, aclk, aresetn, !s_ready, s1_valid_reg && m_valid_reg && !m_ready)
    `RBD_ASSERT_IMPLY(a_frame_end_on_row_end, aclk, aresetn, m_valid_reg && m_data_reg.frame_end, m_data_reg.row_end)
    `RBD_ASSERT_NEXT(a_emit_reaches_stage, aclk, aresetn, s_accept && emit && !cfg_we, s1_valid_reg)

endmodule

`default_nettype wire
